@@ design/pms_pkg.sv @@
// Shared types, constants and the arctangent table for the polar move sequencer.
`default_nettype none

package pms_pkg;

   localparam int unsigned COORD_WIDTH          = 16;
   localparam int unsigned CORDIC_STEPS_DEFAULT = 16;
   localparam int unsigned GUARD_BITS           = 32 - COORD_WIDTH;
   localparam int unsigned ANG_FRAC             = 30;
   localparam int unsigned ANG_DROP             = ANG_FRAC - 13;
   localparam int unsigned XY_WIDTH             = 35;
   localparam int unsigned Z_WIDTH              = 34;
   localparam int unsigned ANG_WIDE             = Z_WIDTH - ANG_DROP;
   localparam int unsigned XU_WIDTH             = XY_WIDTH - 1;
   localparam int unsigned LO_WIDTH             = 17;
   localparam int unsigned HI_WIDTH             = XU_WIDTH - LO_WIDTH;
   localparam int unsigned GAIN_WIDTH           = 30;
   localparam int unsigned PROD_WIDTH           = LO_WIDTH + GAIN_WIDTH;
   localparam int unsigned SUM_WIDTH            = 66;
   localparam int unsigned DIST_SHIFT           = ANG_FRAC + GUARD_BITS;
   localparam int unsigned DIST_WIDE            = SUM_WIDTH - DIST_SHIFT;

   localparam int PI_Q13 = 25736;

   localparam logic signed [Z_WIDTH-1:0] HALF_PI_Z    = Z_WIDTH'(1686629713);
   localparam logic [GAIN_WIDTH-1:0]     INV_GAIN_Q30 = GAIN_WIDTH'(652032874);

   typedef enum logic [1:0] {
      CMD_GOAL       = 2'd0,
      CMD_ROT_DONE   = 2'd1,
      CMD_TRANS_DONE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ROTATE    = 2'd0,
      KIND_TRANSLATE = 2'd1,
      KIND_REACHED   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_CALC,
      PH_ROT,
      PH_TRANS
   } phase_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [15:0] goal_x;
      logic signed [15:0] goal_y;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] angle;
      logic [15:0]        distance;
   } rsp_type;

   typedef struct packed {
      logic                        valid;
      logic signed [XY_WIDTH-1:0]  x;
      logic signed [XY_WIDTH-1:0]  y;
      logic signed [Z_WIDTH-1:0]   z;
   } cell_type;

   typedef struct packed {
      logic               valid;
      logic signed [15:0] angle;
      logic [15:0]        distance;
   } fin_type;

   function automatic logic signed [Z_WIDTH-1:0] atan_z(input int unsigned step);
      int val;
      case (step)
         0:  val = 843314857;
         1:  val = 497837829;
         2:  val = 263043837;
         3:  val = 133525159;
         4:  val = 67021687;
         5:  val = 33543516;
         6:  val = 16775851;
         7:  val = 8388437;
         8:  val = 4194283;
         9:  val = 2097149;
         10: val = 1048576;
         11: val = 524288;
         12: val = 262144;
         13: val = 131072;
         14: val = 65536;
         15: val = 32768;
         16: val = 16384;
         17: val = 8192;
         18: val = 4096;
         19: val = 2048;
         20: val = 1024;
         21: val = 512;
         22: val = 256;
         23: val = 128;
         24: val = 64;
         25: val = 32;
         26: val = 16;
         27: val = 8;
         28: val = 4;
         29: val = 2;
         30: val = 1;
         default: val = 0;
      endcase
      return Z_WIDTH'(val);
   endfunction

endpackage

`default_nettype wire

@@ design/pms_cell.sv @@
// One CORDIC vectoring step with a fixed shift, registered toward the next cell.
`default_nettype none

module pms_cell #(
   parameter int unsigned STEP = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pms_pkg::cell_type prev_cell,
   output pms_pkg::cell_type      next_cell
);
   import pms_pkg::*;

   localparam logic signed [Z_WIDTH-1:0] ATAN = atan_z(STEP);

   logic signed [XY_WIDTH-1:0] xs;
   logic signed [XY_WIDTH-1:0] ys;
   cell_type                   stage_in;
   cell_type                   stage_ff;

   assign xs = prev_cell.x >>> STEP;
   assign ys = prev_cell.y >>> STEP;

   always_comb begin
      stage_in.valid = prev_cell.valid;
      if (!prev_cell.y[XY_WIDTH-1]) begin
         stage_in.x = prev_cell.x + ys;
         stage_in.y = prev_cell.y - xs;
         stage_in.z = prev_cell.z + ATAN;
      end else begin
         stage_in.x = prev_cell.x - ys;
         stage_in.y = prev_cell.y + xs;
         stage_in.z = prev_cell.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.x <= stage_in.x;
      stage_ff.y <= stage_in.y;
      stage_ff.z <= stage_in.z;
   end

   assign next_cell = stage_ff;

endmodule

`default_nettype wire

@@ design/pms_finish.sv @@
// Angle rounding and clamp, gain correction of the magnitude, distance saturation.
`default_nettype none

module pms_finish (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pms_pkg::cell_type last_cell,
   output pms_pkg::fin_type       fin
);
   import pms_pkg::*;

   localparam logic signed [Z_WIDTH-1:0]  ANG_HALF  = Z_WIDTH'(1) <<< (ANG_DROP - 1);
   localparam logic signed [ANG_WIDE-1:0] PI_POS    = ANG_WIDE'(PI_Q13);
   localparam logic signed [ANG_WIDE-1:0] PI_NEG    = ANG_WIDE'(-PI_Q13);
   localparam logic [SUM_WIDTH-1:0]       DIST_HALF = SUM_WIDTH'(1) << (DIST_SHIFT - 1);

   logic signed [Z_WIDTH-1:0]  z_round;
   logic signed [ANG_WIDE-1:0] ang_wide;
   logic signed [15:0]         ang_in;
   logic [XU_WIDTH-1:0]        xu;
   logic [PROD_WIDTH-1:0]      p_lo_in;
   logic [PROD_WIDTH-1:0]      p_hi_in;

   logic                       s1_valid_ff;
   logic signed [15:0]         ang_ff;
   logic [PROD_WIDTH-1:0]      p_lo_ff;
   logic [PROD_WIDTH-1:0]      p_hi_ff;

   logic [SUM_WIDTH-1:0]       sum;
   logic [DIST_WIDE-1:0]       dist_wide;
   fin_type                    fin_in;
   fin_type                    fin_ff;

   // stage 1: angle and two partial products of the gain correction
   assign z_round  = last_cell.z + ANG_HALF;
   assign ang_wide = z_round[Z_WIDTH-1:ANG_DROP];

   always_comb begin
      if (ang_wide > PI_POS) begin
         ang_in = PI_POS[15:0];
      end else if (ang_wide < PI_NEG) begin
         ang_in = PI_NEG[15:0];
      end else begin
         ang_in = ang_wide[15:0];
      end
   end

   assign xu      = last_cell.x[XY_WIDTH-1] ? '0 : last_cell.x[XU_WIDTH-1:0];
   assign p_lo_in = PROD_WIDTH'(xu[LO_WIDTH-1:0]) * PROD_WIDTH'(INV_GAIN_Q30);
   assign p_hi_in = PROD_WIDTH'(xu[XU_WIDTH-1:LO_WIDTH]) * PROD_WIDTH'(INV_GAIN_Q30);

   // stage 2: combine, round, saturate
   assign sum = (SUM_WIDTH'(p_hi_ff) << LO_WIDTH) + SUM_WIDTH'(p_lo_ff) + DIST_HALF;
   assign dist_wide = sum[SUM_WIDTH-1:DIST_SHIFT];

   always_comb begin
      fin_in.valid = s1_valid_ff;
      fin_in.angle = ang_ff;
      if (|dist_wide[DIST_WIDE-1:16]) begin
         fin_in.distance = 16'hFFFF;
      end else begin
         fin_in.distance = dist_wide[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fin_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff  <= last_cell.valid;
         fin_ff.valid <= fin_in.valid;
      end
      ang_ff          <= ang_in;
      p_lo_ff         <= p_lo_in;
      p_hi_ff         <= p_hi_in;
      fin_ff.angle    <= fin_in.angle;
      fin_ff.distance <= fin_in.distance;
   end

   assign fin = fin_ff;

endmodule

`default_nettype wire

@@ design/polar_move_sequencer.sv @@
// Top level of the polar move sequencer: command sequencing, CORDIC cell row, output register.
`default_nettype none

// A goal point (cmd 0) is acted on only while the block waits for one. It is
// pre-rotated into the right half plane and passed down a row of
// CORDIC_STEPS vectoring cells, one cell per cycle; the angle is then rounded
// and the magnitude gain-corrected in two more registered stages. The rotate
// command is loaded once the goal leaves those stages, and only one goal is
// in the cell row at a time; req_stall is high while it is in flight.
// The rotation and translation acknowledgements are answered in the next
// cycle. A goal of (0,0) answers goal reached in the next cycle. Items that do
// not fit the current phase are taken and dropped without a result. The
// result register frees the input side as soon as its transfer completes.
module polar_move_sequencer #(
   parameter int unsigned CORDIC_STEPS = pms_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pms_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pms_pkg::rsp_type      rsp_data
);
   import pms_pkg::*;

   phase_type    state_ff;
   phase_type    state_in;
   logic [15:0]  pending_ff;
   logic [15:0]  pending_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_type      rsp_data_ff;
   rsp_type      rsp_data_in;
   logic         rsp_load;
   logic         start;
   logic         accept;
   logic         rsp_take;
   logic         goal_zero;

   cell_type                  chain [0:CORDIC_STEPS];
   logic [CORDIC_STEPS:0]     chain_valid;
   fin_type                   fin;

   logic signed [XY_WIDTH-1:0] x0;
   logic signed [XY_WIDTH-1:0] y0;

   assign req_stall = (state_ff == PH_CALC) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign goal_zero = (req_data.goal_x == '0) && (req_data.goal_y == '0);

   // scale to 32 bits and turn a left-half-plane point by a quarter turn
   assign x0 = XY_WIDTH'($signed({req_data.goal_x, GUARD_BITS'(0)}));
   assign y0 = XY_WIDTH'($signed({req_data.goal_y, GUARD_BITS'(0)}));

   always_comb begin
      chain[0].valid = start;
      if (x0[XY_WIDTH-1]) begin
         if (!y0[XY_WIDTH-1]) begin
            chain[0].x = y0;
            chain[0].y = -x0;
            chain[0].z = HALF_PI_Z;
         end else begin
            chain[0].x = -y0;
            chain[0].y = x0;
            chain[0].z = -HALF_PI_Z;
         end
      end else begin
         chain[0].x = x0;
         chain[0].y = y0;
         chain[0].z = '0;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      pms_cell #(
         .STEP (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_cell (chain[k]),
         .next_cell (chain[k+1])
      );
   end

   for (genvar k = 0; k <= CORDIC_STEPS; k++) begin : g_valid
      assign chain_valid[k] = chain[k].valid;
   end

   pms_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .last_cell (chain[CORDIC_STEPS]),
      .fin       (fin)
   );

   always_comb begin
      state_in    = state_ff;
      pending_in  = pending_ff;
      rsp_load    = 1'b0;
      start       = 1'b0;
      rsp_data_in = '{kind: KIND_REACHED, angle: '0, distance: '0};
      unique case (state_ff)
         PH_WAIT: begin
            if (accept && req_data.cmd == CMD_GOAL) begin
               if (goal_zero) begin
                  rsp_load = 1'b1;
               end else begin
                  start    = 1'b1;
                  state_in = PH_CALC;
               end
            end
         end
         PH_CALC: begin
            if (fin.valid) begin
               rsp_load             = 1'b1;
               rsp_data_in.kind     = KIND_ROTATE;
               rsp_data_in.angle    = fin.angle;
               pending_in           = fin.distance;
               state_in             = PH_ROT;
            end
         end
         PH_ROT: begin
            if (accept && req_data.cmd == CMD_ROT_DONE) begin
               rsp_load             = 1'b1;
               rsp_data_in.kind     = KIND_TRANSLATE;
               rsp_data_in.distance = pending_ff;
               state_in             = PH_TRANS;
            end
         end
         PH_TRANS: begin
            if (accept && req_data.cmd == CMD_TRANS_DONE) begin
               rsp_load = 1'b1;
               state_in = PH_WAIT;
            end
         end
         default: begin
            state_in = PH_WAIT;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_WAIT;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_fin_in_calc : assert property (@(posedge clock) disable iff (reset)
      fin.valid |-> state_ff == PH_CALC)
      else $error("finished goal outside calculation phase");

   a_calc_out_empty : assert property (@(posedge clock) disable iff (reset)
      state_ff == PH_CALC |-> !rsp_valid_ff)
      else $error("result register busy while a goal is in the cell row");

   a_one_in_row : assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one goal in the cell row");

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == KIND_ROTATE |->
         rsp_data_ff.angle <= 16'sd25736 && rsp_data_ff.angle >= -16'sd25736)
      else $error("rotate angle outside plus or minus pi");
`endif

endmodule

`default_nettype wire
